// ----- sv/gaps_pkg.sv -----
// shared types and constants of the grid path search block
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

	localparam int GRID_ROWS_DEF = 8;
	localparam int GRID_COLS_DEF = 8;

	localparam logic [1:0] CMD_MARK   = 2'd0;
	localparam logic [1:0] CMD_CLEAR  = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	localparam logic [1:0] CFG_LAST_ROW  = 2'd0;
	localparam logic [1:0] CFG_LAST_COL  = 2'd1;
	localparam logic [1:0] CFG_STEP_COST = 2'd2;

	localparam logic [2:0] LAST_ROW_RST  = 3'd7;
	localparam logic [2:0] LAST_COL_RST  = 3'd7;
	localparam logic [7:0] STEP_COST_RST = 8'd10;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] pos_x;
		logic [2:0] pos_y;
		logic [2:0] goal_x;
		logic [2:0] goal_y;
	} item_t;

	typedef struct packed {
		logic [2:0] path_x;
		logic [2:0] path_y;
		logic       found;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [2:0] last_row;
		logic [2:0] last_col;
		logic [7:0] step_cost;
	} cfg_t;

endpackage
`default_nettype wire

// ----- sv/gaps_if.sv -----
// handshake channels of the grid path search block
`timescale 1ns / 1ps
`default_nettype none
interface gaps_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [2:0] pos_x;
	logic [2:0] pos_y;
	logic [2:0] goal_x;
	logic [2:0] goal_y;
	modport source (output valid, cmd, pos_x, pos_y, goal_x, goal_y, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, goal_x, goal_y, output ready);
endinterface

interface gaps_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] path_x;
	logic [2:0] path_y;
	logic       found;
	logic       last;
	modport source (output valid, path_x, path_y, found, last, input ready);
	modport sink (input valid, path_x, path_y, found, last, output ready);
endinterface

interface gaps_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/gaps_alu.sv -----
// shared saturating adder and magnitude compare
`timescale 1ns / 1ps
`default_nettype none
module gaps_alu (
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	output logic      [15:0] sum,
	output logic             gt
);
	logic [16:0] raw;

	assign raw = {1'b0, a} + {1'b0, b};
	assign sum = raw[16] ? 16'hFFFF : raw[15:0];
	assign gt  = a > b;
endmodule
`default_nettype wire

// ----- sv/gaps_ctrl.sv -----
// search sequencer with open queue, cost, parent and path memories
`timescale 1ns / 1ps
`default_nettype none
module gaps_ctrl #(
	parameter int GRID_ROWS = gaps_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = gaps_pkg::GRID_COLS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire gaps_pkg::item_t item,
	input  wire gaps_pkg::cfg_t  cfg,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output gaps_pkg::res_t       res
);
	localparam int EXT_X = (GRID_ROWS < 8) ? GRID_ROWS : 8;
	localparam int EXT_Y = (GRID_COLS < 8) ? GRID_COLS : 8;
	localparam int XW = $clog2(EXT_X);
	localparam int YW = $clog2(EXT_Y);
	localparam int AW = XW + YW;
	localparam int NC = 1 << AW;
	localparam int CW = AW + 1;
	localparam logic [2:0] LIM_X_MAX = 3'(EXT_X - 1);
	localparam logic [2:0] LIM_Y_MAX = 3'(EXT_Y - 1);
	localparam logic [3:0] EXT_X4 = 4'(EXT_X);
	localparam logic [3:0] EXT_Y4 = 4'(EXT_Y);

	typedef struct packed {
		logic [AW-1:0] node;
		logic [15:0]   f;
	} qent_t;

	typedef enum logic [1:0] {
		NB_LEFT  = 2'd0,
		NB_RIGHT = 2'd1,
		NB_UP    = 2'd2,
		NB_DOWN  = 2'd3
	} nb_t;

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_CHK   = 19'h00002,
		S_HEAD  = 19'h00004,
		S_HEADW = 19'h00008,
		S_GCUR  = 19'h00010,
		S_NB    = 19'h00020,
		S_NBCMP = 19'h00040,
		S_FIND  = 19'h00080,
		S_FINDW = 19'h00100,
		S_POP   = 19'h00200,
		S_SI    = 19'h00400,
		S_SIW   = 19'h00800,
		S_SJ    = 19'h01000,
		S_SJW   = 19'h02000,
		S_PW    = 19'h04000,
		S_PR    = 19'h08000,
		S_OUTR  = 19'h10000,
		S_OUTW  = 19'h20000,
		S_FAIL  = 19'h40000
	} state_t;

	function automatic logic [15:0] heur(input logic [2:0] x, input logic [2:0] y,
			input logic [2:0] gx, input logic [2:0] gy, input logic [7:0] s);
		logic [2:0]  dx;
		logic [2:0]  dy;
		logic [3:0]  d;
		logic [11:0] p;
		begin
			dx = (x > gx) ? x - gx : gx - x;
			dy = (y > gy) ? y - gy : gy - y;
			d = {1'b0, dx} + {1'b0, dy};
			p = 12'(d) * 12'(s);
			return 16'(p);
		end
	endfunction

	state_t        state_q;
	logic [NC-1:0] obst_q;
	logic [NC-1:0] open_q;
	logic [NC-1:0] closed_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] nc_q;
	logic [AW-1:0] c_q;
	logic [15:0]   ng_q;
	logic [15:0]   f_q;
	qent_t         e_q;
	nb_t           nb_q;
	logic [2:0]    sx_q;
	logic [2:0]    sy_q;
	logic [2:0]    gx_q;
	logic [2:0]    gy_q;

	qent_t         q_mem [NC];
	logic [15:0]   cost_mem [NC];
	logic [AW-1:0] par_mem [NC];
	logic [AW-1:0] stk_mem [NC];
	qent_t         q_rd_q;
	logic [15:0]   cost_rd_q;
	logic [AW-1:0] par_rd_q;
	logic [AW-1:0] stk_rd_q;

	logic          q_we;
	logic [AW-1:0] q_wa;
	qent_t         q_wd;
	logic [AW-1:0] q_ra;
	logic          cost_we;
	logic [AW-1:0] cost_wa;
	logic [AW-1:0] cost_ra;
	logic          par_we;
	logic [AW-1:0] par_wa;
	logic          stk_we;

	logic [2:0]    lim_x;
	logic [2:0]    lim_y;
	logic [2:0]    cur_x;
	logic [2:0]    cur_y;
	logic [3:0]    nx4;
	logic [3:0]    ny4;
	logic [AW-1:0] nc;
	logic          nb_ok;
	logic [15:0]   h_nb;
	logic [AW-1:0] start_a;
	logic [AW-1:0] goal_a;
	logic          bad;
	logic [15:0]   alu_a;
	logic [15:0]   alu_b;
	logic [15:0]   alu_sum;
	logic          alu_gt;
	logic          find_hit;
	logic [AW-1:0] qa_i;
	logic [AW-1:0] qa_j;
	logic [AW-1:0] qa_jm1;
	logic [AW-1:0] qa_cnt;

	gaps_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sum (alu_sum),
		.gt  (alu_gt)
	);

	assign lim_x = (cfg.last_row < LIM_X_MAX) ? cfg.last_row : LIM_X_MAX;
	assign lim_y = (cfg.last_col < LIM_Y_MAX) ? cfg.last_col : LIM_Y_MAX;
	assign cur_x = 3'(cur_q[AW-1:YW]);
	assign cur_y = 3'(cur_q[YW-1:0]);

	always_comb begin
		nx4 = {1'b0, cur_x};
		ny4 = {1'b0, cur_y};
		unique case (nb_q)
			NB_LEFT:  nx4 = {1'b0, cur_x} - 4'd1;
			NB_RIGHT: nx4 = {1'b0, cur_x} + 4'd1;
			NB_UP:    ny4 = {1'b0, cur_y} + 4'd1;
			NB_DOWN:  ny4 = {1'b0, cur_y} - 4'd1;
			default:  nx4 = {1'b0, cur_x};
		endcase
	end

	assign nc      = {nx4[XW-1:0], ny4[YW-1:0]};
	assign nb_ok   = (nx4 <= {1'b0, lim_x}) && (ny4 <= {1'b0, lim_y})
		&& !obst_q[nc] && !closed_q[nc];
	assign h_nb    = heur(nx4[2:0], ny4[2:0], gx_q, gy_q, cfg.step_cost);
	assign start_a = {sx_q[XW-1:0], sy_q[YW-1:0]};
	assign goal_a  = {gx_q[XW-1:0], gy_q[YW-1:0]};
	assign bad     = (sx_q > lim_x) || (sy_q > lim_y) || (gx_q > lim_x) || (gy_q > lim_y);
	assign find_hit = q_rd_q.node == nc_q;
	assign qa_i    = base_q + i_q[AW-1:0];
	assign qa_j    = base_q + j_q[AW-1:0];
	assign qa_jm1  = base_q + j_q[AW-1:0] - AW'(1);
	assign qa_cnt  = base_q + cnt_q[AW-1:0];

	always_comb begin
		alu_a = ng_q;
		alu_b = h_nb;
		unique case (state_q)
			S_GCUR: begin
				alu_a = cost_rd_q;
				alu_b = {8'd0, cfg.step_cost};
			end
			S_NBCMP: begin
				alu_a = cost_rd_q;
				alu_b = ng_q;
			end
			S_SJW: begin
				alu_a = q_rd_q.f;
				alu_b = e_q.f;
			end
			default: begin
				alu_a = ng_q;
				alu_b = h_nb;
			end
		endcase
	end

	always_comb begin
		q_we    = 1'b0;
		q_wa    = qa_i;
		q_wd    = e_q;
		q_ra    = qa_i;
		cost_we = 1'b0;
		cost_wa = nc;
		cost_ra = nc;
		par_we  = 1'b0;
		par_wa  = nc;
		stk_we  = 1'b0;
		unique case (state_q)
			S_CHK: begin
				q_we      = !bad;
				q_wa      = '0;
				q_wd.node = start_a;
				q_wd.f    = heur(sx_q, sy_q, gx_q, gy_q, cfg.step_cost);
				cost_we   = !bad;
				cost_wa   = start_a;
			end
			S_HEAD: q_ra = base_q;
			S_HEADW: cost_ra = q_rd_q.node;
			S_NB: begin
				q_we      = nb_ok && !open_q[nc];
				q_wa      = qa_cnt;
				q_wd.node = nc;
				q_wd.f    = alu_sum;
				cost_we   = nb_ok && !open_q[nc];
				par_we    = nb_ok && !open_q[nc];
			end
			S_NBCMP: begin
				cost_we = alu_gt;
				cost_wa = nc_q;
				par_we  = alu_gt;
				par_wa  = nc_q;
			end
			S_FINDW: begin
				q_we      = find_hit;
				q_wd.node = nc_q;
				q_wd.f    = f_q;
			end
			S_SJ: begin
				q_we = j_q == '0;
				q_wa = qa_j;
				q_ra = qa_jm1;
			end
			S_SJW: begin
				q_we = 1'b1;
				q_wa = qa_j;
				q_wd = alu_gt ? q_rd_q : e_q;
			end
			S_PW: stk_we = 1'b1;
			default: q_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		q_rd_q <= q_mem[q_ra];
		if (cost_we) begin
			cost_mem[cost_wa] <= (state_q == S_CHK) ? 16'd0 : ng_q;
		end
		cost_rd_q <= cost_mem[cost_ra];
		if (par_we) begin
			par_mem[par_wa] <= cur_q;
		end
		par_rd_q <= par_mem[c_q];
		if (stk_we) begin
			stk_mem[n_q[AW-1:0]] <= c_q;
		end
		stk_rd_q <= stk_mem[k_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			obst_q   <= '0;
			open_q   <= '0;
			closed_q <= '0;
			base_q   <= '0;
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			n_q      <= '0;
			k_q      <= '0;
			nb_q     <= NB_LEFT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						sx_q <= item.pos_x;
						sy_q <= item.pos_y;
						gx_q <= item.goal_x;
						gy_q <= item.goal_y;
						if ((item.cmd == gaps_pkg::CMD_MARK || item.cmd == gaps_pkg::CMD_CLEAR)
								&& {1'b0, item.pos_x} < EXT_X4 && {1'b0, item.pos_y} < EXT_Y4) begin
							obst_q[{item.pos_x[XW-1:0], item.pos_y[YW-1:0]}] <=
								item.cmd == gaps_pkg::CMD_MARK;
						end
						if (item.cmd == gaps_pkg::CMD_SEARCH) begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (bad) begin
						state_q <= S_FAIL;
					end else begin
						closed_q <= '0;
						open_q   <= {{(NC-1){1'b0}}, 1'b1} << start_a;
						base_q   <= '0;
						cnt_q    <= CW'(1);
						state_q  <= S_HEAD;
					end
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					cur_q <= q_rd_q.node;
					nb_q  <= NB_LEFT;
					if (q_rd_q.node == goal_a) begin
						n_q     <= '0;
						c_q     <= goal_a;
						state_q <= S_PW;
					end else begin
						state_q <= S_GCUR;
					end
				end
				S_GCUR: begin
					ng_q    <= alu_sum;
					state_q <= S_NB;
				end
				S_NB: begin
					nc_q <= nc;
					f_q  <= alu_sum;
					if (nb_ok && open_q[nc]) begin
						state_q <= S_NBCMP;
					end else begin
						if (nb_ok) begin
							open_q[nc] <= 1'b1;
							cnt_q      <= cnt_q + CW'(1);
						end
						if (nb_q == NB_DOWN) begin
							state_q <= S_POP;
						end else begin
							nb_q <= nb_t'(nb_q + 2'd1);
						end
					end
				end
				S_NBCMP: begin
					i_q <= '0;
					if (alu_gt) begin
						state_q <= S_FIND;
					end else if (nb_q == NB_DOWN) begin
						state_q <= S_POP;
					end else begin
						nb_q    <= nb_t'(nb_q + 2'd1);
						state_q <= S_NB;
					end
				end
				S_FIND: state_q <= S_FINDW;
				S_FINDW: begin
					if (!find_hit) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_FIND;
					end else if (nb_q == NB_DOWN) begin
						state_q <= S_POP;
					end else begin
						nb_q    <= nb_t'(nb_q + 2'd1);
						state_q <= S_NB;
					end
				end
				S_POP: begin
					closed_q[cur_q] <= 1'b1;
					open_q[cur_q]   <= 1'b0;
					base_q          <= base_q + AW'(1);
					cnt_q           <= cnt_q - CW'(1);
					i_q             <= CW'(1);
					state_q         <= S_SI;
				end
				S_SI: begin
					if (i_q >= cnt_q) begin
						state_q <= (cnt_q == '0) ? S_FAIL : S_HEAD;
					end else begin
						state_q <= S_SIW;
					end
				end
				S_SIW: begin
					e_q     <= q_rd_q;
					j_q     <= i_q;
					state_q <= S_SJ;
				end
				S_SJ: begin
					if (j_q == '0) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SI;
					end else begin
						state_q <= S_SJW;
					end
				end
				S_SJW: begin
					if (alu_gt) begin
						j_q     <= j_q - CW'(1);
						state_q <= S_SJ;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SI;
					end
				end
				S_PW: begin
					n_q <= n_q + CW'(1);
					if (c_q == start_a) begin
						k_q     <= n_q;
						state_q <= S_OUTR;
					end else begin
						state_q <= S_PR;
					end
				end
				S_PR: begin
					c_q     <= par_rd_q;
					state_q <= S_PW;
				end
				S_OUTR: state_q <= S_OUTW;
				S_OUTW: begin
					if (res_ready) begin
						if (k_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q - CW'(1);
							state_q <= S_OUTR;
						end
					end
				end
				S_FAIL: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready = state_q == S_IDLE;
	assign res_valid  = (state_q == S_OUTW) || (state_q == S_FAIL);

	always_comb begin
		if (state_q == S_OUTW) begin
			res.path_x = 3'(stk_rd_q[AW-1:YW]);
			res.path_y = 3'(stk_rd_q[YW-1:0]);
			res.found  = 1'b1;
			res.last   = k_q == '0;
		end else begin
			res.path_x = 3'd0;
			res.path_y = 3'd0;
			res.found  = 1'b0;
			res.last   = 1'b1;
		end
	end
endmodule
`default_nettype wire

// ----- sv/grid_astar_path_search.sv -----
// top level: config registers, search sequencer and result output register
//
//  channel  dir  payload                              accepted when
//  item     in   cmd, pos_x, pos_y, goal_x, goal_y    item.valid & item.ready
//  result   out  path_x, path_y, found, last          result.valid & result.ready
//  cfg      in   index, data                          cfg.valid & cfg.ready (always ready)
//
// obstacle commands keep ready high
// a search checks the endpoints, then for each expanded cell reads the queue head and its cost,
// tries the four neighbors, rescans the queue to rewrite a cheaper cost, and insertion-sorts
// the open entries; then it traces the parent links and emits the path cells
// reset needs no clearing pass; the open and closed marks are cleared at each search's endpoint check
// results wait in an output register; the sequencer holds while it is full and result.ready is low
`timescale 1ns / 1ps
`default_nettype none
module grid_astar_path_search #(
	parameter int GRID_ROWS = gaps_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS = gaps_pkg::GRID_COLS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	gaps_in_if.sink     item,
	gaps_out_if.source  result,
	gaps_cfg_if.sink    cfg
);
	gaps_pkg::cfg_t  cfg_q;
	gaps_pkg::item_t item_w;
	gaps_pkg::res_t  res_w;
	gaps_pkg::res_t  out_q;
	logic            out_valid_q;
	logic            res_valid;
	logic            res_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.last_row  <= gaps_pkg::LAST_ROW_RST;
			cfg_q.last_col  <= gaps_pkg::LAST_COL_RST;
			cfg_q.step_cost <= gaps_pkg::STEP_COST_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gaps_pkg::CFG_LAST_ROW:  cfg_q.last_row  <= cfg.data[2:0];
				gaps_pkg::CFG_LAST_COL:  cfg_q.last_col  <= cfg.data[2:0];
				gaps_pkg::CFG_STEP_COST: cfg_q.step_cost <= cfg.data;
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	assign item_w.cmd    = item.cmd;
	assign item_w.pos_x  = item.pos_x;
	assign item_w.pos_y  = item.pos_y;
	assign item_w.goal_x = item.goal_x;
	assign item_w.goal_y = item.goal_y;

	gaps_ctrl #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.item       (item_w),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res_w)
	);

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_w;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.path_x = out_q.path_x;
	assign result.path_y = out_q.path_y;
	assign result.found  = out_q.found;
	assign result.last   = out_q.last;
endmodule
`default_nettype wire

// ----- sv/gaps_chk.sv -----
// port checker for the grid path search block and its bind
`timescale 1ns / 1ps
`default_nettype none
module gaps_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [1:0] in_cmd,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] out_x,
	input wire logic [2:0] out_y,
	input wire logic       out_found,
	input wire logic       out_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_x, out_y, out_found, out_last}))
		else $error("result word changed while stalled");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == gaps_pkg::CMD_SEARCH |=> !in_ready)
		else $error("ready after search word");

	a_obst_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd != gaps_pkg::CMD_SEARCH |=> in_ready)
		else $error("obstacle word stalled input");

	a_fail_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_last && out_x == 3'd0 && out_y == 3'd0)
		else $error("malformed not-found word");
endmodule

bind grid_astar_path_search gaps_chk u_gaps_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_cmd    (item.cmd),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_x     (result.path_x),
	.out_y     (result.path_y),
	.out_found (result.found),
	.out_last  (result.last)
);
`default_nettype wire
